// ----- rtl/core/brb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast ring buffer package
// Shared field widths, default sizes and operation and status codes.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int DEPTH_DEF   = 8192;
  localparam int READERS_DEF = 8;

  localparam int KIND_W   = 2;
  localparam int ID_W     = 3;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 3;
  localparam int FREE_W   = 13;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_ATTACH = 2'd2,
    KIND_DETACH = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_NOT_ATT = 3'd3,
    ST_ALREADY = 3'd4
  } status_t;

endpackage

// ----- rtl/core/brb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module brb_ram
  import brb_pkg::*;
#(
  parameter int WIDTH = DATA_W,
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/broadcast_ring_buffer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast ring buffer
// One writer, several readers with their own read pointers, one byte store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: kind (push, pop, attach, detach), reader_id, wdata.
//   Each accepted transfer yields exactly one result transfer on out_*:
//   status, rdata (byte of a successful pop, else zero) and free_space.
//   An item runs through the steps execute (pointer update and store access),
//   distance (per-reader pending counts registered, store read data taken),
//   finish (max tree over the readers, pointer collapse, result load).
//   in_stall is low only in the execute slot, so the block takes a new item
//   only once the last one has passed the finish step, which loads the result.
//   The pop path reads the byte store, a RAM with registered read data.
//   The result register lets the next item enter while a result waits.
//   When out_stall holds a result and the next one is ready, the finish
//   step holds until the pending result is taken.
//   Reset detaches all readers and clears every pointer; the store itself
//   is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module broadcast_ring_buffer_unit
  import brb_pkg::*;
#(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int READERS = READERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [ID_W-1:0]     in_reader_id,
  input  logic [DATA_W-1:0]   in_wdata,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [DATA_W-1:0]   out_rdata,
  output logic [FREE_W-1:0]   out_free_space
);

  localparam int PW     = $clog2(DEPTH);
  localparam int RW     = (READERS > 1) ? $clog2(READERS) : 1;
  localparam int LVL    = $clog2(READERS);
  localparam int TREE_N = 2 ** LVL;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIST,
    S_FIN
  } state_t;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  function automatic logic [PW-1:0] ptr_dist(input logic [PW-1:0] from,
                                             input logic [PW-1:0] to);
    logic [PW:0] t;
    t = {1'b0, to} - {1'b0, from};
    if (to < from) begin
      t = t + (PW+1)'(DEPTH);
    end
    return t[PW-1:0];
  endfunction

  state_t             state_r, state_nxt;
  logic [PW-1:0]      wp_r, wp_nxt;
  logic [PW-1:0]      used_r, used_nxt;
  logic [PW-1:0]      rp_r [READERS];
  logic [PW-1:0]      rp_nxt [READERS];
  logic [READERS-1:0] act_r, act_nxt;
  logic [PW-1:0]      dist_r [READERS];
  logic [PW-1:0]      dist_nxt [READERS];
  status_t            st_r, st_nxt;
  logic               pop_ok_r, pop_ok_nxt;
  logic [DATA_W-1:0]  rd_r, rd_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [DATA_W-1:0]  out_rdata_r, out_rdata_nxt;
  logic [FREE_W-1:0]  out_free_r, out_free_nxt;

  logic               accept;
  logic               id_ok;
  logic [RW-1:0]      idx;
  logic               sel_act;
  logic               any_act;
  logic               ram_we;
  logic               ram_re;
  logic [PW-1:0]      ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;
  logic [PW-1:0]      node [2*TREE_N];
  logic [PW-1:0]      maxd;
  logic [PW-1:0]      free_pw;
  logic               out_free_slot;

  assign accept        = in_valid && (state_r == S_IDLE);
  assign id_ok         = 32'(in_reader_id) < READERS;
  assign idx           = RW'(in_reader_id);
  assign sel_act       = id_ok && act_r[idx];
  assign any_act       = |act_r;
  assign out_free_slot = !out_valid_r || !out_stall;

  always_comb begin
    for (int n = 0; n < 2 * TREE_N; n++) begin
      node[n] = '0;
    end
    for (int i = 0; i < READERS; i++) begin
      node[TREE_N + i] = dist_r[i];
    end
    for (int n = TREE_N - 1; n >= 1; n--) begin
      node[n] = (node[2*n] > node[2*n+1]) ? node[2*n] : node[2*n+1];
    end
    maxd = node[1];
  end

  assign free_pw = PW'(DEPTH - 1) - maxd;

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    used_nxt       = used_r;
    act_nxt        = act_r;
    st_nxt         = st_r;
    pop_ok_nxt     = pop_ok_r;
    rd_nxt         = rd_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_rdata_nxt  = out_rdata_r;
    out_free_nxt   = out_free_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    for (int i = 0; i < READERS; i++) begin
      rp_nxt[i]   = rp_r[i];
      dist_nxt[i] = dist_r[i];
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          st_nxt     = ST_OK;
          pop_ok_nxt = 1'b0;
          unique case (kind_t'(in_kind))
            KIND_PUSH: begin
              if (!any_act) begin
                st_nxt = ST_OK;
              end else if (used_r >= PW'(DEPTH - 1)) begin
                st_nxt = ST_FULL;
              end else begin
                ram_we = 1'b1;
                wp_nxt = ptr_inc(wp_r);
              end
            end
            KIND_POP: begin
              if (!sel_act) begin
                st_nxt = ST_NOT_ATT;
              end else if (rp_r[idx] == wp_r) begin
                st_nxt = ST_EMPTY;
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = rp_r[idx];
                rp_nxt[idx] = ptr_inc(rp_r[idx]);
                pop_ok_nxt  = 1'b1;
              end
            end
            KIND_ATTACH: begin
              if (!id_ok) begin
                st_nxt = ST_NOT_ATT;
              end else if (act_r[idx]) begin
                st_nxt = ST_ALREADY;
              end else begin
                act_nxt[idx] = 1'b1;
                rp_nxt[idx]  = wp_r;
              end
            end
            KIND_DETACH: begin
              if (!sel_act) begin
                st_nxt = ST_NOT_ATT;
              end else begin
                act_nxt[idx] = 1'b0;
              end
            end
            default: begin
              st_nxt = ST_NOT_ATT;
            end
          endcase
          state_nxt = S_DIST;
        end
      end
      S_DIST: begin
        for (int i = 0; i < READERS; i++) begin
          dist_nxt[i] = act_r[i] ? ptr_dist(rp_r[i], wp_r) : '0;
        end
        rd_nxt    = pop_ok_r ? ram_rdata : '0;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free_slot) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_rdata_nxt  = rd_r;
          out_free_nxt   = FREE_W'(free_pw);
          used_nxt       = maxd;
          if (maxd == '0) begin
            wp_nxt = '0;
            for (int i = 0; i < READERS; i++) begin
              rp_nxt[i] = '0;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      used_r      <= '0;
      act_r       <= '0;
      pop_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < READERS; i++) begin
        rp_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      used_r      <= used_nxt;
      act_r       <= act_nxt;
      pop_ok_r    <= pop_ok_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < READERS; i++) begin
        rp_r[i] <= rp_nxt[i];
      end
    end
    st_r         <= st_nxt;
    rd_r         <= rd_nxt;
    out_status_r <= out_status_nxt;
    out_rdata_r  <= out_rdata_nxt;
    out_free_r   <= out_free_nxt;
    for (int i = 0; i < READERS; i++) begin
      dist_r[i] <= dist_nxt[i];
    end
  end

  brb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_rdata      = out_rdata_r;
  assign out_free_space = out_free_r;

`ifndef SYNTH
  a_idle_empty_collapsed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && used_r == '0) |-> (wp_r == '0))
    else $error("write pointer not collapsed with no retained data");

  a_no_reader_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !any_act) |-> (used_r == '0))
    else $error("retained data with no reader attached");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (any_act && used_r < PW'(DEPTH - 1)))
    else $error("store written while full or without readers");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside the finish step");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= PW'(DEPTH - 1))
    else $error("retained count beyond usable depth");
`endif

endmodule
